@@ hw/rtl/hlpf_pkg.sv @@
// ----------------------------------------------------------------------------
// hlpf_pkg: shared types, constants and helpers for the header line filter
// Holds store geometry, character codes, line phase codes, configuration
// register indexes and the slot evaluation result type.
// ----------------------------------------------------------------------------
package hlpf_pkg;

    // Store geometry
    localparam int MAX_PATTERNS  = 16;
    localparam int PATTERN_CHARS = 32;
    localparam int SLOT_W        = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int POS_W         = (PATTERN_CHARS > 1) ? $clog2(PATTERN_CHARS) : 1;
    localparam int NPOS_W        = $clog2(PATTERN_CHARS + 1);
    localparam int CNT_W         = $clog2(MAX_PATTERNS + 1);
    localparam int ROW_W         = PATTERN_CHARS * 8;

    // Character codes
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // Line phase codes
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_BLANK = 2'd1;
    localparam logic [1:0] PH_TOKEN = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_FILTER_ENABLED = 1'b0;
    localparam logic CFG_PATTERN_COUNT  = 1'b1;

    // One pattern slot as a single memory row
    typedef logic [ROW_W-1:0] row_t;

    // Verdict on one slot for the current name byte
    typedef struct packed {
        logic kill;   // slot mismatches at this name position
        logic match;  // slot pattern is a non-empty prefix of the name so far
    } slot_eval_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            r = c + CASE_GAP;
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

@@ hw/rtl/header_line_prefix_filter.sv @@
// ----------------------------------------------------------------------------
// header_line_prefix_filter: per-line keep/drop verdict on header patterns
// Tracks the line phase byte by byte, walks the pattern memory one slot a
// cycle for each name byte and at the end of a checked header line, and
// delivers one verdict word per ended line.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                  payload
//   item      in         item_valid / item_ready    req_type, data_byte,
//                                                   end_of_response, pattern_index,
//                                                   char_index, char_value
//   result    out        result_valid / result_ready keep_line, response_done
//   cfg       in         cfg_write (no wait)        cfg_index, cfg_data
//
// A pattern write or a byte outside the name needs no scan. A name byte reads
// one memory row per slot through the single read port. A line end passes the
// decision and output states, and reads up to count rows when a header line is
// checked against the patterns.
// After reset a clearing pass zeroes every memory row while item_ready is low;
// configuration writes are taken throughout.
// A stalled result waits in the output register while later words are taken;
// the next line end then holds until the waiting word leaves.
// ----------------------------------------------------------------------------
module header_line_prefix_filter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic       req_type,
    input  logic [7:0] data_byte,
    input  logic       end_of_response,
    input  logic [3:0] pattern_index,
    input  logic [4:0] char_index,
    input  logic [7:0] char_value,
    output logic       result_valid,
    input  logic       result_ready,
    output logic       keep_line,
    output logic       response_done,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [4:0] cfg_data
);
    import hlpf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_DEC  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    hit_reg, hit_next;
    logic [7:0]              char_reg, char_next;
    logic                    eor_reg, eor_next;
    logic [MAX_PATTERNS-1:0] alive_reg, alive_next;
    logic [NPOS_W-1:0]       npos_reg, npos_next;
    logic [1:0]              phase_reg, phase_next;
    logic                    lead_reg, lead_next;
    logic                    cont_reg, cont_next;
    logic                    verdict_reg, verdict_next;
    logic                    pend_keep_reg, pend_keep_next;
    logic                    pend_done_reg, pend_done_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_keep_reg, out_keep_next;
    logic                    out_done_reg, out_done_next;
    logic                    filter_en_reg;
    logic [4:0]              pat_count_reg;

    logic                    item_accept;
    logic                    clr_busy;
    logic                    wr_en;
    logic                    rd_en;
    row_t                    rd_row;
    slot_eval_t              slot_res;
    logic [CNT_W-1:0]        count_eff;
    logic [CNT_W-1:0]        scan_len;
    logic [CNT_W-1:0]        eval_cnt;
    logic [SLOT_W-1:0]       eval_slot;
    logic                    eval_on;
    logic                    scan_end;
    logic                    dec_scan;
    logic                    bypass_keep;
    logic                    cur_hit;
    logic                    tok;
    logic                    do_cmp;
    logic                    go_dec;
    logic                    finish;
    logic                    dec_keep;

    // Handshake and pattern writes
    assign item_ready  = (state_reg == ST_IDLE) && !clr_busy;
    assign item_accept = item_valid && item_ready;
    assign wr_en       = item_accept && req_type
                         && (int'(pattern_index) < MAX_PATTERNS)
                         && (int'(char_index) < PATTERN_CHARS);

    // Scan control: one slot read issued per cycle, judged the cycle after
    assign count_eff = (int'(pat_count_reg) > MAX_PATTERNS) ? CNT_W'(MAX_PATTERNS)
                                                             : CNT_W'(pat_count_reg);
    assign scan_len  = (state_reg == ST_CMP) ? CNT_W'(MAX_PATTERNS) : count_eff;
    assign rd_en     = ((state_reg == ST_CMP) || (state_reg == ST_DEC)) && (cnt_reg < scan_len);
    assign eval_cnt  = cnt_reg - CNT_W'(1);
    assign eval_slot = eval_cnt[SLOT_W-1:0];
    assign eval_on   = (cnt_reg != '0);
    assign scan_end  = (cnt_reg == scan_len);

    // Line end verdict inputs
    assign dec_scan    = filter_en_reg && (count_eff != '0) && (phase_reg == PH_DONE)
                         && verdict_reg;
    assign bypass_keep = (!filter_en_reg || (count_eff == '0)) ? 1'b1 : (cont_reg && lead_reg);
    assign cur_hit     = hit_reg || (eval_on && alive_reg[eval_slot] && slot_res.match);

    hlpf_pat_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_slot  (pattern_index[SLOT_W-1:0]),
        .wr_pos   (char_index[POS_W-1:0]),
        .wr_char  (char_value),
        .rd_en    (rd_en),
        .rd_slot  (cnt_reg[SLOT_W-1:0]),
        .rd_row   (rd_row),
        .clr_busy (clr_busy)
    );

    hlpf_slot_eval u_eval (
        .row       (rd_row),
        .name_pos  (npos_reg),
        .name_char (char_reg),
        .result    (slot_res)
    );

    // Next state of the sequencer and line state
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        char_next      = char_reg;
        eor_next       = eor_reg;
        alive_next     = alive_reg;
        npos_next      = npos_reg;
        phase_next     = phase_reg;
        lead_next      = lead_reg;
        cont_next      = cont_reg;
        verdict_next   = verdict_reg;
        pend_keep_next = pend_keep_reg;
        pend_done_next = pend_done_reg;
        out_valid_next = out_valid_reg;
        out_keep_next  = out_keep_reg;
        out_done_next  = out_done_reg;
        tok            = 1'b0;
        do_cmp         = 1'b0;
        go_dec         = 1'b0;
        finish         = 1'b0;
        dec_keep       = bypass_keep;

        // Drop the output word once taken
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept && !req_type)
                begin
                    char_next = to_lower(data_byte);
                    eor_next  = end_of_response;
                    cnt_next  = '0;
                    hit_next  = 1'b0;
                    go_dec    = (data_byte == CH_NL) || end_of_response;
                    if (data_byte != CH_NL)
                    begin
                        case (phase_reg)
                            PH_START:
                            begin
                                if (is_blank(data_byte))
                                begin
                                    lead_next  = 1'b1;
                                    phase_next = PH_BLANK;
                                end
                                else
                                begin
                                    tok = 1'b1;
                                end
                            end
                            PH_BLANK: tok = !is_blank(data_byte);
                            PH_TOKEN: tok = 1'b1;
                            default:  tok = 1'b0;
                        endcase
                        if (tok)
                        begin
                            if (data_byte == CH_COLON)
                            begin
                                verdict_next = (npos_reg != '0);
                                phase_next   = PH_DONE;
                            end
                            else if (is_blank(data_byte) || (data_byte == CH_CR))
                            begin
                                verdict_next = 1'b0;
                                phase_next   = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_TOKEN;
                                do_cmp     = (npos_reg < NPOS_W'(PATTERN_CHARS));
                            end
                        end
                    end
                    if (do_cmp)
                    begin
                        state_next = ST_CMP;
                    end
                    else if (go_dec)
                    begin
                        state_next = ST_DEC;
                    end
                end
            end
            ST_CMP:
            begin
                if (eval_on && slot_res.kill)
                begin
                    alive_next[eval_slot] = 1'b0;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (scan_end)
                begin
                    npos_next  = npos_reg + NPOS_W'(1);
                    cnt_next   = '0;
                    state_next = eor_reg ? ST_DEC : ST_IDLE;
                end
            end
            ST_DEC:
            begin
                if (!dec_scan)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    hit_next = cur_hit;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (scan_end)
                    begin
                        dec_keep  = cur_hit;
                        cont_next = cur_hit;
                        finish    = 1'b1;
                    end
                end
                if (finish)
                begin
                    pend_keep_next = dec_keep;
                    pend_done_next = eor_reg;
                    if (eor_reg)
                    begin
                        cont_next = 1'b0;
                    end
                    alive_next   = '1;
                    npos_next    = '0;
                    phase_next   = PH_START;
                    lead_next    = 1'b0;
                    verdict_next = 1'b0;
                    cnt_next     = '0;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_keep_next  = pend_keep_reg;
                    out_done_next  = pend_done_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold sequencer, line state and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            char_reg      <= '0;
            eor_reg       <= 1'b0;
            alive_reg     <= '1;
            npos_reg      <= '0;
            phase_reg     <= PH_START;
            lead_reg      <= 1'b0;
            cont_reg      <= 1'b0;
            verdict_reg   <= 1'b0;
            pend_keep_reg <= 1'b0;
            pend_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_keep_reg  <= 1'b0;
            out_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            char_reg      <= char_next;
            eor_reg       <= eor_next;
            alive_reg     <= alive_next;
            npos_reg      <= npos_next;
            phase_reg     <= phase_next;
            lead_reg      <= lead_next;
            cont_reg      <= cont_next;
            verdict_reg   <= verdict_next;
            pend_keep_reg <= pend_keep_next;
            pend_done_reg <= pend_done_next;
            out_valid_reg <= out_valid_next;
            out_keep_reg  <= out_keep_next;
            out_done_reg  <= out_done_next;
        end
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_en_reg <= 1'b0;
            pat_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FILTER_ENABLED: filter_en_reg <= cfg_data[0];
                CFG_PATTERN_COUNT:  pat_count_reg <= cfg_data;
                default:            filter_en_reg <= filter_en_reg;
            endcase
        end
    end

    assign result_valid  = out_valid_reg;
    assign keep_line     = out_keep_reg;
    assign response_done = out_done_reg;

endmodule

@@ hw/rtl/hlpf_pat_store.sv @@
// ----------------------------------------------------------------------------
// hlpf_pat_store: pattern memory, one row per slot
// Byte-lane writes of lowered pattern characters, one registered row read
// per cycle, and a clearing pass over all rows after reset.
// ----------------------------------------------------------------------------
module hlpf_pat_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [hlpf_pkg::SLOT_W-1:0] wr_slot,
    input  logic [hlpf_pkg::POS_W-1:0]  wr_pos,
    input  logic [7:0]                 wr_char,
    input  logic                       rd_en,
    input  logic [hlpf_pkg::SLOT_W-1:0] rd_slot,
    output hlpf_pkg::row_t             rd_row,
    output logic                       clr_busy
);
    import hlpf_pkg::*;

    row_t             mem [MAX_PATTERNS];
    row_t             rd_row_reg;
    logic [CNT_W-1:0] clr_cnt_reg;
    logic [CNT_W-1:0] clr_cnt_next;

    assign clr_busy = (clr_cnt_reg != CNT_W'(MAX_PATTERNS));
    assign rd_row   = rd_row_reg;

    // Advance the clearing pass one row a cycle
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (clr_busy)
        begin
            clr_cnt_next = clr_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Clear, write one byte lane, read one row
    always_ff @(posedge clk)
    begin
        if (clr_busy)
        begin
            mem[clr_cnt_reg[SLOT_W-1:0]] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_slot][{wr_pos, 3'b000} +: 8] <= to_lower(wr_char);
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_slot];
        end
    end

endmodule

@@ hw/rtl/hlpf_slot_eval.sv @@
// ----------------------------------------------------------------------------
// hlpf_slot_eval: judge one stored pattern row against the name
// Finds the pattern end from the zero bytes of the row, flags a mismatch at
// the current name position and reports a completed prefix match.
// ----------------------------------------------------------------------------
module hlpf_slot_eval (
    input  hlpf_pkg::row_t              row,
    input  logic [hlpf_pkg::NPOS_W-1:0] name_pos,
    input  logic [7:0]                  name_char,
    output hlpf_pkg::slot_eval_t        result
);
    import hlpf_pkg::*;

    logic [PATTERN_CHARS-1:0] zero_map;
    logic [PATTERN_CHARS-1:0] upto_mask;
    logic [7:0]               pos_byte;
    logic                     at_end;

    // Mark zero bytes and the positions up to the name position
    always_comb
    begin
        for (int k = 0; k < PATTERN_CHARS; k++)
        begin
            zero_map[k]  = (row[8*k +: 8] == 8'h00);
            upto_mask[k] = (NPOS_W'(k) <= name_pos);
        end
    end

    assign at_end   = (name_pos >= NPOS_W'(PATTERN_CHARS));
    assign pos_byte = row[{name_pos[POS_W-1:0], 3'b000} +: 8];

    // Drop the slot when the pattern still runs here and the byte differs
    assign result.kill  = !at_end && !(|(zero_map & upto_mask)) && (pos_byte != name_char);
    // Non-empty pattern that ended within the name seen so far
    assign result.match = !zero_map[0] && (at_end || (|(zero_map & upto_mask)));

endmodule

@@ hw/rtl/hlpf_checker.sv @@
// ----------------------------------------------------------------------------
// hlpf_checker: port-level checks for the header line filter
// Watches the item and result channels around reset, pattern writes and
// line ends, and is bound to the top level.
// ----------------------------------------------------------------------------
module hlpf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic       req_type,
    input logic [7:0] data_byte,
    input logic       result_valid,
    input logic       result_ready,
    input logic       keep_line,
    input logic       response_done
);
    import hlpf_pkg::*;

    // Hold a stalled result word
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(keep_line)
                                          && $stable(response_done))
        else $error("result word changed while stalled");

    // Block items while the pattern memory is cleared
    a_clear_blocks: assert property (@(posedge clk)
        $rose(rst_n) |-> !item_ready)
        else $error("item taken during clearing pass");

    // Pattern writes do not stall the item channel
    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && req_type |=> item_ready)
        else $error("pattern write stalled the item channel");

    // A newline always goes through the line end verdict
    a_newline_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && !req_type && (data_byte == CH_NL) |=> !item_ready)
        else $error("newline taken without a verdict step");

    // A new result word is only loaded after the block stopped taking items
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(item_ready))
        else $error("result word appeared without a verdict step");

endmodule

bind header_line_prefix_filter hlpf_checker u_hlpf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .req_type      (req_type),
    .data_byte     (data_byte),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .keep_line     (keep_line),
    .response_done (response_done)
);
